// ===== rtl/bascc_pkg.sv =====
// ----------------------------------------------------------------------------
// bascc_pkg
// Types, constants and helpers shared by the serial BCD add/subtract/compare
// core and its sub-blocks.
// ----------------------------------------------------------------------------
package bascc_pkg;

    localparam logic [3:0] DEC_MAX  = 4'd9;
    localparam logic [4:0] DEC_BASE = 5'd10;

    // Running order of the digits seen so far
    localparam logic [1:0] ORDER_EQUAL   = 2'd0;
    localparam logic [1:0] ORDER_GREATER = 2'd1;
    localparam logic [1:0] ORDER_LESS    = 2'd2;

    typedef struct packed {
        logic [3:0] digit_a;
        logic [3:0] digit_b;
        logic       last_digit;
    } t_in;

    typedef struct packed {
        logic [3:0] sum_digit;
        logic [3:0] diff_digit;
        logic       final_flags;
        logic       sum_overflow;
        logic       diff_borrow;
        logic       a_equal_b;
        logic       a_greater_b;
        logic       a_less_b;
        logic       a_is_zero;
        logic       b_is_zero;
    } t_out;

    // Classified digit pair handed from the front end to the back end
    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic       last;
        logic       a_gt_b;
        logic       a_lt_b;
        logic       a_nz;
        logic       b_nz;
    } t_cls;

    // Clamp codes above nine to nine
    function automatic logic [3:0] sat_digit(input logic [3:0] d);
        logic [3:0] r;
        r = (d > DEC_MAX) ? DEC_MAX : d;
        return r;
    endfunction

endpackage

// ===== rtl/bascc_front.sv =====
// ----------------------------------------------------------------------------
// bascc_front
// Input stage: accept a digit pair, clamp the digits and classify the pair.
// ----------------------------------------------------------------------------
module bascc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bascc_pkg::t_in     i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output bascc_pkg::t_cls    o_cls
);

    logic            r_valid;
    bascc_pkg::t_cls r_cls;
    bascc_pkg::t_cls n_cls;
    logic [3:0]      w_a;
    logic [3:0]      w_b;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cls   = r_cls;

    always_comb begin
        w_a          = bascc_pkg::sat_digit(i_data.digit_a);
        w_b          = bascc_pkg::sat_digit(i_data.digit_b);
        n_cls.a      = w_a;
        n_cls.b      = w_b;
        n_cls.last   = i_data.last_digit;
        n_cls.a_gt_b = (w_a > w_b);
        n_cls.a_lt_b = (w_a < w_b);
        n_cls.a_nz   = (w_a != 4'd0);
        n_cls.b_nz   = (w_b != 4'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cls <= n_cls;
        end
    end

endmodule

// ===== rtl/bascc_queue.sv =====
// ----------------------------------------------------------------------------
// bascc_queue
// Short register queue between front and back end.
// ----------------------------------------------------------------------------
module bascc_queue #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bascc_pkg::t_cls    i_cls,
    output logic               o_valid,
    input  logic               i_ready,
    output bascc_pkg::t_cls    o_cls
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    bascc_pkg::t_cls r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            w_wr;
    logic            w_rd;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cls   = r_mem[r_rd_ptr];
    assign w_wr    = i_valid && o_ready;
    assign w_rd    = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + CW'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

endmodule

// ===== rtl/bascc_back.sv =====
// ----------------------------------------------------------------------------
// bascc_back
// Digit arithmetic: decimal sum and difference, running order and zero
// tracking, final flags on the marked last pair, and the output register.
// ----------------------------------------------------------------------------
module bascc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bascc_pkg::t_cls    i_cls,
    output logic               o_valid,
    input  logic               i_ready,
    output bascc_pkg::t_out    o_data
);

    logic            r_carry;
    logic            r_borrow;
    logic [1:0]      r_order;
    logic            r_a_nz;
    logic            r_b_nz;
    logic            r_out_valid;
    bascc_pkg::t_out r_out;

    logic            n_carry;
    logic            n_borrow;
    logic [1:0]      n_order;
    logic            n_a_nz;
    logic            n_b_nz;
    bascc_pkg::t_out n_out;

    logic            w_take;
    logic [4:0]      w_sum;
    logic [4:0]      w_sum_adj;
    logic [4:0]      w_sub;
    logic [4:0]      w_diff;

    assign o_ready = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        w_sum     = {1'b0, i_cls.a} + {1'b0, i_cls.b} + {4'd0, r_carry};
        n_carry   = (w_sum > {1'b0, bascc_pkg::DEC_MAX});
        w_sum_adj = n_carry ? (w_sum - bascc_pkg::DEC_BASE) : w_sum;

        w_sub     = {1'b0, i_cls.b} + {4'd0, r_borrow};
        n_borrow  = ({1'b0, i_cls.a} < w_sub);
        w_diff    = n_borrow ? ({1'b0, i_cls.a} + bascc_pkg::DEC_BASE - w_sub)
                             : ({1'b0, i_cls.a} - w_sub);

        if (i_cls.a_gt_b) begin
            n_order = bascc_pkg::ORDER_GREATER;
        end else if (i_cls.a_lt_b) begin
            n_order = bascc_pkg::ORDER_LESS;
        end else begin
            n_order = r_order;
        end
        n_a_nz = r_a_nz || i_cls.a_nz;
        n_b_nz = r_b_nz || i_cls.b_nz;

        n_out              = '0;
        n_out.sum_digit    = w_sum_adj[3:0];
        n_out.diff_digit   = w_diff[3:0];
        if (i_cls.last) begin
            n_out.final_flags  = 1'b1;
            n_out.sum_overflow = n_carry;
            n_out.diff_borrow  = n_borrow;
            n_out.a_equal_b    = (n_order == bascc_pkg::ORDER_EQUAL);
            n_out.a_greater_b  = (n_order == bascc_pkg::ORDER_GREATER);
            n_out.a_less_b     = (n_order == bascc_pkg::ORDER_LESS);
            n_out.a_is_zero    = !n_a_nz;
            n_out.b_is_zero    = !n_b_nz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry     <= 1'b0;
            r_borrow    <= 1'b0;
            r_order     <= bascc_pkg::ORDER_EQUAL;
            r_a_nz      <= 1'b0;
            r_b_nz      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (w_take) begin
                if (i_cls.last) begin
                    // Number complete: clear for the next one
                    r_carry  <= 1'b0;
                    r_borrow <= 1'b0;
                    r_order  <= bascc_pkg::ORDER_EQUAL;
                    r_a_nz   <= 1'b0;
                    r_b_nz   <= 1'b0;
                end else begin
                    r_carry  <= n_carry;
                    r_borrow <= n_borrow;
                    r_order  <= n_order;
                    r_a_nz   <= n_a_nz;
                    r_b_nz   <= n_b_nz;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end

    a_order_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.final_flags) |->
        $onehot({r_out.a_equal_b, r_out.a_greater_b, r_out.a_less_b}))
        else $error("order flags not one-hot on final digit");

    a_flags_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.final_flags) |->
        ({r_out.sum_overflow, r_out.diff_borrow, r_out.a_equal_b, r_out.a_greater_b,
          r_out.a_less_b, r_out.a_is_zero, r_out.b_is_zero} == 7'd0))
        else $error("flags set on a non-final digit");

    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_cls.last) |=>
        (!r_carry && !r_borrow && !r_a_nz && !r_b_nz &&
         r_order == bascc_pkg::ORDER_EQUAL))
        else $error("running state not cleared after last digit");

endmodule

// ===== rtl/bcd_add_sub_compare_core.sv =====
// ----------------------------------------------------------------------------
// bcd_add_sub_compare_core
// Serial BCD adder, subtractor and comparator, one digit pair per transfer.
// ----------------------------------------------------------------------------
// Path: a result passes the front register, one queue slot and the output
//   register before it is offered.
// Throughput: one digit pair per cycle while the output is not stalled by
//   i_out_ready.
// Reset: synchronous, active low; empties front, queue and output register
//   and clears carry, borrow, order and zero tracking.
// ----------------------------------------------------------------------------
module bcd_add_sub_compare_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bascc_pkg::t_in     i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bascc_pkg::t_out    o_out_data
);

    // Front end to queue
    logic            w_fq_valid;
    logic            w_fq_ready;
    bascc_pkg::t_cls w_fq_cls;

    // Queue to back end
    logic            w_qb_valid;
    logic            w_qb_ready;
    bascc_pkg::t_cls w_qb_cls;

    // Clamp and classify each incoming pair; hold it while the queue is full
    bascc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (w_fq_valid),
        .i_ready (w_fq_ready),
        .o_cls   (w_fq_cls)
    );

    // Decouple the two sides so a stalled output does not stop transfers at once
    bascc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .o_ready (w_fq_ready),
        .i_cls   (w_fq_cls),
        .o_valid (w_qb_valid),
        .i_ready (w_qb_ready),
        .o_cls   (w_qb_cls)
    );

    // Advance carry, borrow and order per digit; report flags on the last one
    bascc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qb_valid),
        .o_ready (w_qb_ready),
        .i_cls   (w_qb_cls),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
